@@ sv/cdsu_pkg.sv @@
package cdsu_pkg;

  typedef enum logic [1:0] {
    OP_TO_DATE    = 2'd0,
    OP_TO_SERIAL  = 2'd1,
    OP_ADD_MONTHS = 2'd2,
    OP_ADD_DAYS   = 2'd3
  } op_t;

  localparam int unsigned SERIAL_MIN = 2;
  localparam int unsigned SERIAL_MAX = 2958465;
  localparam int unsigned YEAR_MIN   = 1900;
  localparam int unsigned YEAR_MAX   = 9999;

  // Month index (year * 12 + month - 1) limits for the add-months path.
  localparam int unsigned MIDX_MIN = YEAR_MIN * 12;
  localparam int unsigned MIDX_MAX = YEAR_MAX * 12 + 11;

  // serial = day + march_days + 365*y' + y'/4 - y'/100 + y'/400 - SERIAL_BASE,
  // where y' is the year counted from March.
  localparam int unsigned SERIAL_BASE = 693900;
  // Offset from the serial count to the day number used by the inverse conversion.
  localparam int unsigned JDN_SHIFT   = 2447063;
  localparam int unsigned DAYS_400Y   = 146097;
  localparam int unsigned DAYS_4Y     = 1461;
  localparam int unsigned EPOCH_YEARS = 4800;

  // Reciprocals for division by constants; each is exact over the full
  // operand width at its use.
  localparam int unsigned DIV100_SH  = 21;
  localparam logic [14:0] DIV100_MUL =
    15'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
  localparam int unsigned DIV12_SH   = 21;
  localparam logic [17:0] DIV12_MUL  =
    18'(((64'd1 << DIV12_SH) + 64'd11) / 64'd12);
  localparam int unsigned DIV400Y_SH  = 43;
  localparam logic [25:0] DIV400Y_MUL =
    26'(((64'd1 << DIV400Y_SH) + 64'd146096) / 64'd146097);
  localparam int unsigned DIV4Y_SH   = 31;
  localparam logic [20:0] DIV4Y_MUL  =
    21'(((64'd1 << DIV4Y_SH) + 64'd1460) / 64'd1461);
  localparam int unsigned DIV153_SH  = 19;
  localparam logic [11:0] DIV153_MUL =
    12'(((64'd1 << DIV153_SH) + 64'd152) / 64'd153);

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first day of month index mm (March is zero).
  function automatic logic [8:0] march_days(input logic [3:0] mm);
    logic [8:0] n;
    unique case (mm)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd61;
      4'd3:    n = 9'd92;
      4'd4:    n = 9'd122;
      4'd5:    n = 9'd153;
      4'd6:    n = 9'd184;
      4'd7:    n = 9'd214;
      4'd8:    n = 9'd245;
      4'd9:    n = 9'd275;
      4'd10:   n = 9'd306;
      4'd11:   n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // q100 is the year divided by 100.
  function automatic logic is_century(input logic [13:0] yr, input logic [7:0] q100);
    logic [13:0] rem;
    rem = yr - 14'(q100) * 14'd100;
    return rem == 14'd0;
  endfunction

  function automatic logic leap_year(input logic [13:0] yr, input logic [7:0] q100);
    return (yr[1:0] == 2'd0) && (!is_century(yr, q100) || q100[1:0] == 2'd0);
  endfunction

endpackage

@@ sv/calendar_date_serial_unit.sv @@
// Every stage below is registered. Throughput: one word per cycle while
// rsp_stall is low; the chain of reciprocal multiplies that turns a serial
// count back into a date is cut into one multiply per stage.
// A stalled result holds while earlier stages keep filling their bubbles.
// Reset clears the stage valid bits only; the data registers are not reset.
module calendar_date_serial_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         op,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [21:0]        serial_day,
  input  logic signed [22:0] offset,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [21:0]        out_serial,
  output logic [4:0]         days_in_month,
  output logic               is_leap,
  output logic               error
);

  localparam int NS = 14;

  logic [NS:1] vld;
  logic [NS:1] vld_in;
  logic [NS:1] en;

  assign vld_in = {vld[NS-1:1], req_valid};

  // A stage may load when the output moves or some stage at or after it is empty.
  generate
    for (genvar k = 1; k <= NS; k++) begin : g_en
      assign en[k] = !rsp_stall || !(&vld[NS:k]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (en & vld_in) | (~en & vld);
    end
  end

  assign req_stall = !en[1];
  assign rsp_valid = vld[NS];

  // Stage 1: year / 100, month index, range checks.
  logic [28:0] c1_prod;
  logic [7:0]  c1_yq;
  logic [24:0] c1_t;

  assign c1_prod = 29'(year) * 29'(cdsu_pkg::DIV100_MUL);
  assign c1_yq   = 8'(c1_prod >> cdsu_pkg::DIV100_SH);
  assign c1_t    = 25'(year) * 25'd12 + 25'(month) - 25'd1 + {{2{offset[22]}}, offset};

  cdsu_pkg::op_t s1_op;
  logic [13:0]   s1_year;
  logic [3:0]    s1_month;
  logic [4:0]    s1_day;
  logic [21:0]   s1_serial;
  logic [22:0]   s1_off;
  logic [7:0]    s1_yq;
  logic [24:0]   s1_t;
  logic          s1_y_ok;
  logic          s1_m_ok;
  logic          s1_s_ok;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op     <= cdsu_pkg::op_t'(op);
      s1_year   <= year;
      s1_month  <= month;
      s1_day    <= day;
      s1_serial <= serial_day;
      s1_off    <= offset;
      s1_yq     <= c1_yq;
      s1_t      <= c1_t;
      s1_y_ok   <= year >= 14'(cdsu_pkg::YEAR_MIN) && year <= 14'(cdsu_pkg::YEAR_MAX);
      s1_m_ok   <= month >= 4'd1 && month <= 4'd12;
      s1_s_ok   <= serial_day >= 22'(cdsu_pkg::SERIAL_MIN)
                   && serial_day <= 22'(cdsu_pkg::SERIAL_MAX);
    end
  end

  // Stage 2: input date check, month index divided by 12.
  logic        c2_leap;
  logic [4:0]  c2_mlen;
  logic [16:0] c2_u;
  logic [34:0] c2_prod;

  assign c2_leap = cdsu_pkg::leap_year(s1_year, s1_yq);
  assign c2_mlen = cdsu_pkg::month_len(s1_month, c2_leap);
  assign c2_u    = 17'(s1_t - 25'(cdsu_pkg::MIDX_MIN));
  assign c2_prod = 35'(c2_u) * 35'(cdsu_pkg::DIV12_MUL);

  cdsu_pkg::op_t s2_op;
  logic [13:0]   s2_year;
  logic [3:0]    s2_month;
  logic [4:0]    s2_day;
  logic [21:0]   s2_serial;
  logic [22:0]   s2_off;
  logic          s2_s_ok;
  logic          s2_date_ok;
  logic          s2_t_ok;
  logic [16:0]   s2_u;
  logic [12:0]   s2_mq;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_op      <= s1_op;
      s2_year    <= s1_year;
      s2_month   <= s1_month;
      s2_day     <= s1_day;
      s2_serial  <= s1_serial;
      s2_off     <= s1_off;
      s2_s_ok    <= s1_s_ok;
      s2_date_ok <= s1_y_ok && s1_m_ok && s1_day != 5'd0 && s1_day <= c2_mlen;
      s2_t_ok    <= $signed(s1_t) >= $signed(25'(cdsu_pkg::MIDX_MIN))
                    && $signed(s1_t) <= $signed(25'(cdsu_pkg::MIDX_MAX));
      s2_u       <= c2_u;
      s2_mq      <= 13'(c2_prod >> cdsu_pkg::DIV12_SH);
    end
  end

  // Stage 3: pick the date to convert, year / 100 of that date.
  logic [3:0]  c3_rm;
  logic [13:0] c3_y;
  logic [3:0]  c3_m;
  logic [28:0] c3_prod;

  assign c3_rm   = 4'(s2_u - 17'(s2_mq) * 17'd12) + 4'd1;
  assign c3_y    = (s2_op == cdsu_pkg::OP_ADD_MONTHS)
                   ? 14'(cdsu_pkg::YEAR_MIN) + 14'(s2_mq) : s2_year;
  assign c3_m    = (s2_op == cdsu_pkg::OP_ADD_MONTHS) ? c3_rm : s2_month;
  assign c3_prod = 29'(c3_y) * 29'(cdsu_pkg::DIV100_MUL);

  cdsu_pkg::op_t s3_op;
  logic [13:0]   s3_y;
  logic [3:0]    s3_m;
  logic [4:0]    s3_day;
  logic [21:0]   s3_serial;
  logic [22:0]   s3_off;
  logic          s3_s_ok;
  logic          s3_date_ok;
  logic          s3_t_ok;
  logic [7:0]    s3_yq;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_op      <= s2_op;
      s3_y       <= c3_y;
      s3_m       <= c3_m;
      s3_day     <= s2_day;
      s3_serial  <= s2_serial;
      s3_off     <= s2_off;
      s3_s_ok    <= s2_s_ok;
      s3_date_ok <= s2_date_ok;
      s3_t_ok    <= s2_t_ok;
      s3_yq      <= 8'(c3_prod >> cdsu_pkg::DIV100_SH);
    end
  end

  // Stage 4: clamp the day, move to a year that starts in March.
  logic        c4_cent;
  logic        c4_leap;
  logic [4:0]  c4_mlen;
  logic        c4_early;

  assign c4_cent  = cdsu_pkg::is_century(s3_y, s3_yq);
  assign c4_leap  = cdsu_pkg::leap_year(s3_y, s3_yq);
  assign c4_mlen  = cdsu_pkg::month_len(s3_m, c4_leap);
  assign c4_early = s3_m <= 4'd2;

  cdsu_pkg::op_t s4_op;
  logic [4:0]    s4_day;
  logic [3:0]    s4_mm;
  logic [13:0]   s4_yp;
  logic [7:0]    s4_qp;
  logic [21:0]   s4_serial;
  logic [22:0]   s4_off;
  logic          s4_s_ok;
  logic          s4_date_ok;
  logic          s4_t_ok;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_op      <= s3_op;
      s4_day     <= (s3_day > c4_mlen) ? c4_mlen : s3_day;
      s4_mm      <= c4_early ? s3_m + 4'd9 : s3_m - 4'd3;
      s4_yp      <= s3_y - 14'(c4_early);
      // One year back crosses a century boundary only from a round century.
      s4_qp      <= (c4_early && c4_cent) ? s3_yq - 8'd1 : s3_yq;
      s4_serial  <= s3_serial;
      s4_off     <= s3_off;
      s4_s_ok    <= s3_s_ok;
      s4_date_ok <= s3_date_ok;
      s4_t_ok    <= s3_t_ok;
    end
  end

  // Stage 5: date to serial count.
  logic [21:0] c5_ds;

  assign c5_ds = 22'(24'(s4_day) + 24'(cdsu_pkg::march_days(s4_mm))
                     + 24'(s4_yp) * 24'd365 + 24'(s4_yp >> 2)
                     - 24'(s4_qp) + 24'(s4_qp >> 2)
                     - 24'(cdsu_pkg::SERIAL_BASE));

  cdsu_pkg::op_t s5_op;
  logic [21:0]   s5_ds;
  logic [21:0]   s5_serial;
  logic [22:0]   s5_off;
  logic          s5_s_ok;
  logic          s5_date_ok;
  logic          s5_t_ok;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_op      <= s4_op;
      s5_ds      <= c5_ds;
      s5_serial  <= s4_serial;
      s5_off     <= s4_off;
      s5_s_ok    <= s4_s_ok;
      s5_date_ok <= s4_date_ok;
      s5_t_ok    <= s4_t_ok;
    end
  end

  // Stage 6: day offset, error decision, serial count to convert back.
  logic [24:0] c6_ns;
  logic        c6_ns_ok;
  logic [21:0] c6_cs;
  logic        c6_err;

  assign c6_ns    = 25'(s5_ds) + {{2{s5_off[22]}}, s5_off};
  assign c6_ns_ok = $signed(c6_ns) >= $signed(25'(cdsu_pkg::SERIAL_MIN))
                    && $signed(c6_ns) <= $signed(25'(cdsu_pkg::SERIAL_MAX));

  always_comb begin
    unique case (s5_op)
      cdsu_pkg::OP_TO_DATE: begin
        c6_cs  = s5_serial;
        c6_err = !s5_s_ok;
      end
      cdsu_pkg::OP_TO_SERIAL: begin
        c6_cs  = s5_ds;
        c6_err = !s5_date_ok;
      end
      cdsu_pkg::OP_ADD_MONTHS: begin
        c6_cs  = s5_ds;
        c6_err = !s5_date_ok || !s5_t_ok;
      end
      cdsu_pkg::OP_ADD_DAYS: begin
        c6_cs  = 22'(c6_ns);
        c6_err = !s5_date_ok || !c6_ns_ok;
      end
      default: begin
        c6_cs  = s5_serial;
        c6_err = 1'b1;
      end
    endcase
  end

  logic [21:0] s6_cs;
  logic        s6_err;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_cs  <= c6_cs;
      s6_err <= c6_err;
    end
  end

  // Stage 7: 400-year cycle number. Every result, even a plain date to serial,
  // is rebuilt from its serial count so the tail is shared by all operations.
  logic [22:0] c7_a;
  logic [50:0] c7_prod;

  assign c7_a    = 23'(s6_cs) + 23'(cdsu_pkg::JDN_SHIFT);
  assign c7_prod = 51'({c7_a, 2'b11}) * 51'(cdsu_pkg::DIV400Y_MUL);

  logic [22:0] s7_a;
  logic [7:0]  s7_b;
  logic [21:0] s7_cs;
  logic        s7_err;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_a   <= c7_a;
      s7_b   <= 8'(c7_prod >> cdsu_pkg::DIV400Y_SH);
      s7_cs  <= s6_cs;
      s7_err <= s6_err;
    end
  end

  // Stage 8: day within the 400-year cycle.
  logic [17:0] c8_c;

  assign c8_c = 18'(s7_a - 23'((26'(s7_b) * 26'(cdsu_pkg::DAYS_400Y)) >> 2));

  logic [7:0]  s8_b;
  logic [17:0] s8_c;
  logic [21:0] s8_cs;
  logic        s8_err;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_b   <= s7_b;
      s8_c   <= c8_c;
      s8_cs  <= s7_cs;
      s8_err <= s7_err;
    end
  end

  // Stage 9: year within the cycle.
  logic [40:0] c9_prod;

  assign c9_prod = 41'({s8_c, 2'b11}) * 41'(cdsu_pkg::DIV4Y_MUL);

  logic [7:0]  s9_b;
  logic [17:0] s9_c;
  logic [8:0]  s9_e4;
  logic [21:0] s9_cs;
  logic        s9_err;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_b   <= s8_b;
      s9_c   <= s8_c;
      s9_e4  <= 9'(c9_prod >> cdsu_pkg::DIV4Y_SH);
      s9_cs  <= s8_cs;
      s9_err <= s8_err;
    end
  end

  // Stage 10: day within the March-based year.
  logic [8:0] c10_e;

  assign c10_e = 9'(s9_c - 18'((21'(s9_e4) * 21'(cdsu_pkg::DAYS_4Y)) >> 2));

  logic [7:0]  s10_b;
  logic [8:0]  s10_e;
  logic [8:0]  s10_e4;
  logic [21:0] s10_cs;
  logic        s10_err;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_b   <= s9_b;
      s10_e   <= c10_e;
      s10_e4  <= s9_e4;
      s10_cs  <= s9_cs;
      s10_err <= s9_err;
    end
  end

  // Stage 11: month within the March-based year.
  logic [10:0] c11_x;
  logic [22:0] c11_prod;

  assign c11_x    = 11'(12'(s10_e) * 12'd5 + 12'd2);
  assign c11_prod = 23'(c11_x) * 23'(cdsu_pkg::DIV153_MUL);

  logic [7:0]  s11_b;
  logic [8:0]  s11_e;
  logic [8:0]  s11_e4;
  logic [3:0]  s11_mm;
  logic [21:0] s11_cs;
  logic        s11_err;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_b   <= s10_b;
      s11_e   <= s10_e;
      s11_e4  <= s10_e4;
      s11_mm  <= 4'(c11_prod >> cdsu_pkg::DIV153_SH);
      s11_cs  <= s10_cs;
      s11_err <= s10_err;
    end
  end

  // Stage 12: calendar year, month and day.
  logic c12_wrap;

  assign c12_wrap = s11_mm >= 4'd10;

  logic [13:0] s12_year;
  logic [3:0]  s12_mon;
  logic [4:0]  s12_day;
  logic [21:0] s12_cs;
  logic        s12_err;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_year <= 14'(15'(s11_b) * 15'd100 + 15'(s11_e4)
                      - 15'(cdsu_pkg::EPOCH_YEARS) + 15'(c12_wrap));
      s12_mon  <= c12_wrap ? s11_mm - 4'd9 : s11_mm + 4'd3;
      s12_day  <= 5'(s11_e - cdsu_pkg::march_days(s11_mm) + 9'd1);
      s12_cs   <= s11_cs;
      s12_err  <= s11_err;
    end
  end

  // Stage 13: year / 100 for the leap-year flag.
  logic [28:0] c13_prod;

  assign c13_prod = 29'(s12_year) * 29'(cdsu_pkg::DIV100_MUL);

  logic [13:0] s13_year;
  logic [3:0]  s13_mon;
  logic [4:0]  s13_day;
  logic [21:0] s13_cs;
  logic        s13_err;
  logic [7:0]  s13_yq;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      s13_year <= s12_year;
      s13_mon  <= s12_mon;
      s13_day  <= s12_day;
      s13_cs   <= s12_cs;
      s13_err  <= s12_err;
      s13_yq   <= 8'(c13_prod >> cdsu_pkg::DIV100_SH);
    end
  end

  // Stage 14: output register.
  logic       c14_leap;
  logic [4:0] c14_mlen;

  assign c14_leap = cdsu_pkg::leap_year(s13_year, s13_yq);
  assign c14_mlen = cdsu_pkg::month_len(s13_mon, c14_leap);

  always_ff @(posedge clk) begin
    if (en[14]) begin
      if (s13_err) begin
        out_year      <= '0;
        out_month     <= '0;
        out_day       <= '0;
        out_serial    <= '0;
        days_in_month <= '0;
        is_leap       <= 1'b0;
        error         <= 1'b1;
      end else begin
        out_year      <= s13_year;
        out_month     <= s13_mon;
        out_day       <= s13_day;
        out_serial    <= s13_cs;
        days_in_month <= c14_mlen;
        is_leap       <= c14_leap;
        error         <= 1'b0;
      end
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> out_year == 14'd0 && out_month == 4'd0 && out_day == 5'd0
                           && out_serial == 22'd0 && days_in_month == 5'd0 && !is_leap)
    else $error("error word carries nonzero fields");

  a_date_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !error |-> out_month >= 4'd1 && out_month <= 4'd12 && out_day != 5'd0
                            && out_day <= days_in_month && days_in_month >= 5'd28)
    else $error("result date is not a calendar date");

  a_serial_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !error |-> out_serial >= 22'(cdsu_pkg::SERIAL_MIN)
                            && out_serial <= 22'(cdsu_pkg::SERIAL_MAX))
    else $error("result serial count out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled while the output is free");

endmodule
